// File: design/first_match_packet_filter_unit_assert.svh
// Assertion macros for the first-match packet filter.
`ifndef FIRST_MATCH_PACKET_FILTER_UNIT_ASSERT_SVH
`define FIRST_MATCH_PACKET_FILTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

`define FMPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define FMPF_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define FMPF_ASSERT(label, prop, msg)

`define FMPF_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// File: design/fmpf_pkg.sv
// Types and constants shared by the first-match packet filter.
package fmpf_pkg;

  localparam int RULE_SLOTS_DEF = 64;

  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [1:0] SEL_ANY   = 2'd0;
  localparam logic [1:0] SEL_TCP   = 2'd1;
  localparam logic [1:0] SEL_UDP   = 2'd2;
  localparam logic [1:0] SEL_OTHER = 2'd3;

  localparam logic [7:0] IP_PROTO_TCP = 8'd6;
  localparam logic [7:0] IP_PROTO_UDP = 8'd17;

  localparam logic ACTION_ALLOW = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  rule_index;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        src_any;
    logic        dst_any;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [1:0]  proto_select;
    logic [7:0]  ip_protocol;
    logic        ports_present;
    logic        allow_action;
  } fmpf_req_t;

  typedef struct packed {
    logic       permit;
    logic       matched;
    logic [5:0] match_index;
  } fmpf_rsp_t;

  // One stored rule.
  typedef struct packed {
    logic        src_any;
    logic [31:0] src_addr;
    logic        dst_any;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [1:0]  proto_sel;
    logic        allow;
  } fmpf_rule_t;

  // Packet header walking down the cell row.
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  ip_protocol;
    logic        ports_present;
  } fmpf_hdr_t;

  // Search status handed from cell to cell.
  typedef struct packed {
    logic       valid;
    logic       hit;
    logic       permit;
    logic [5:0] index;
  } fmpf_carry_t;

endpackage

// File: design/fmpf_cell.sv
// One rule cell: holds a rule and checks the passing header against it.
module fmpf_cell
  import fmpf_pkg::*;
#(
  parameter int CellIdx = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_idx_i,
  input  fmpf_rule_t  wr_rule_i,
  input  logic [6:0]  rule_count_i,
  input  fmpf_hdr_t   hdr_i,
  input  fmpf_carry_t carry_i,
  output fmpf_hdr_t   hdr_o,
  output fmpf_carry_t carry_o
);

  fmpf_rule_t  rule_q;
  fmpf_hdr_t   hdr_q;
  logic        valid_q;
  logic        hit_q, hit_d;
  logic        permit_q, permit_d;
  logic [5:0]  index_q, index_d;

  logic active;
  logic src_ok, dst_ok, proto_ok, tcp_udp, ports_ok, rule_hit;

  // Store the rule when the write targets this slot.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_idx_i) == 32'(CellIdx))) begin
      rule_q <= wr_rule_i;
    end
  end

  always_comb begin
    active   = 32'(rule_count_i) > 32'(CellIdx);
    src_ok   = rule_q.src_any || (rule_q.src_addr == hdr_i.src_addr);
    dst_ok   = rule_q.dst_any || (rule_q.dst_addr == hdr_i.dst_addr);
    proto_ok = !((rule_q.proto_sel == SEL_TCP) && (hdr_i.ip_protocol != IP_PROTO_TCP)) &&
               !((rule_q.proto_sel == SEL_UDP) && (hdr_i.ip_protocol != IP_PROTO_UDP));
    tcp_udp  = (hdr_i.ip_protocol == IP_PROTO_TCP) || (hdr_i.ip_protocol == IP_PROTO_UDP);
    ports_ok = !(tcp_udp && hdr_i.ports_present) ||
               (((rule_q.src_port == '0) || (rule_q.src_port == hdr_i.src_port)) &&
                ((rule_q.dst_port == '0) || (rule_q.dst_port == hdr_i.dst_port)));
    rule_hit = active && src_ok && dst_ok && proto_ok && ports_ok;

    hit_d    = carry_i.hit;
    permit_d = carry_i.permit;
    index_d  = carry_i.index;
    // Take the first hit only; later cells pass it through.
    if (!carry_i.hit && rule_hit) begin
      hit_d    = 1'b1;
      permit_d = rule_q.allow;
      index_d  = 6'(CellIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= carry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_i;
    hit_q    <= hit_d;
    permit_q <= permit_d;
    index_q  <= index_d;
  end

  assign hdr_o          = hdr_q;
  assign carry_o.valid  = valid_q;
  assign carry_o.hit    = hit_q;
  assign carry_o.permit = permit_q;
  assign carry_o.index  = index_q;

endmodule

// File: design/first_match_packet_filter_unit.sv
// Write result: done_o in the cycle after the request is accepted; busy stays low.
// Classify result: done_o once the header has passed the RuleSlots cells, moving
// one rule cell per cycle; busy stays high through the result cycle and blocks
// new requests. Results are shown for one cycle and cannot be stalled.
// Reset clears rule_count and the control flops; the rule table is not cleared.
`include "first_match_packet_filter_unit_assert.svh"

module first_match_packet_filter_unit
  import fmpf_pkg::*;
#(
  parameter int RuleSlots = RULE_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  fmpf_req_t  req_i,
  output logic       done_o,
  output fmpf_rsp_t  rsp_o,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i
);

  logic        accept, accept_wr, accept_cls;
  logic        busy_q, busy_d;
  logic        wr_done_q;
  logic [6:0]  rule_count_q;
  logic        chain_done;
  fmpf_rule_t  wr_rule;
  fmpf_hdr_t   hdr_w   [RuleSlots+1];
  fmpf_carry_t carry_w [RuleSlots+1];

  assign accept     = start && !busy_q;
  assign accept_wr  = accept && (req_i.opcode == OP_WRITE);
  assign accept_cls = accept && (req_i.opcode == OP_CLASSIFY);

  always_comb begin
    wr_rule.src_any   = req_i.src_any;
    wr_rule.src_addr  = req_i.src_addr;
    wr_rule.dst_any   = req_i.dst_any;
    wr_rule.dst_addr  = req_i.dst_addr;
    wr_rule.src_port  = req_i.src_port;
    wr_rule.dst_port  = req_i.dst_port;
    wr_rule.proto_sel = req_i.proto_select;
    wr_rule.allow     = req_i.allow_action;
  end

  assign hdr_w[0] = {req_i.src_addr, req_i.dst_addr, req_i.src_port, req_i.dst_port,
                     req_i.ip_protocol, req_i.ports_present};

  // No match yet: allow by default.
  assign carry_w[0] = {accept_cls, 1'b0, ACTION_ALLOW, 6'd0};

  for (genvar g = 0; g < RuleSlots; g++) begin : g_cell
    fmpf_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (accept_wr),
      .wr_idx_i    (req_i.rule_index),
      .wr_rule_i   (wr_rule),
      .rule_count_i(rule_count_q),
      .hdr_i       (hdr_w[g]),
      .carry_i     (carry_w[g]),
      .hdr_o       (hdr_w[g+1]),
      .carry_o     (carry_w[g+1])
    );
  end

  assign chain_done = carry_w[RuleSlots].valid;

  always_comb begin
    busy_d = busy_q;
    if (chain_done) begin
      busy_d = 1'b0;
    end
    if (accept_cls) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      wr_done_q    <= 1'b0;
      rule_count_q <= '0;
    end else begin
      busy_q    <= busy_d;
      wr_done_q <= accept_wr;
      if (cfg_we_i) begin
        rule_count_q <= cfg_wdata_i;
      end
    end
  end

  assign busy   = busy_q;
  assign done_o = wr_done_q || chain_done;

  always_comb begin
    rsp_o.permit      = ACTION_ALLOW;
    rsp_o.matched     = 1'b0;
    rsp_o.match_index = '0;
    if (chain_done) begin
      rsp_o.permit      = carry_w[RuleSlots].permit;
      rsp_o.matched     = carry_w[RuleSlots].hit;
      rsp_o.match_index = carry_w[RuleSlots].index;
    end
  end

  `FMPF_ASSERT(a_chain_only_busy, chain_done |-> busy_q, "classify result outside busy window")
  `FMPF_ASSERT_NEVER(a_one_result, wr_done_q && chain_done, "write and classify results collide")
  `FMPF_ASSERT(a_cls_sets_busy, accept_cls |=> busy_q, "busy not raised after classify request")
  `FMPF_ASSERT(a_nomatch_allow, (done_o && !rsp_o.matched) |-> rsp_o.permit,
               "unmatched result must allow")

endmodule
